/* design/mcw_pkg.sv */
// Package for the multi-channel check-in watchdog.
// Field widths, command and report codes, cell bus types. No dependencies.
package mcw_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W   = 2;
    localparam int CH_W    = 4;
    localparam int TIME_W  = 32;
    localparam int MEM_W   = 40;
    localparam int KIND_W  = 3;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 80;

    localparam logic [CMD_W-1:0] CMD_CHECKIN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECKOUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    localparam logic [KIND_W-1:0] RPT_CHECKIN_OK  = 3'd0;
    localparam logic [KIND_W-1:0] RPT_CHECKOUT_OK = 3'd1;
    localparam logic [KIND_W-1:0] RPT_DBL_CHECKIN = 3'd2;
    localparam logic [KIND_W-1:0] RPT_DBL_CHECKOUT = 3'd3;
    localparam logic [KIND_W-1:0] RPT_TIMEOUT     = 3'd4;
    localparam logic [KIND_W-1:0] RPT_LATE_CHKOUT = 3'd5;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd60;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic              adv;     // shift the scan token one cell on
        logic              chk_rd;  // channel-addressed read active
        logic [CH_W-1:0]   ch;
        logic              wr_in;   // check in the addressed channel
        logic              clr_in;  // check out the addressed channel
        logic              mark;    // set timed-out mark in the token cell
        logic [TIME_W-1:0] tick;
        logic [MEM_W-1:0]  mem;
    } t_cell_ctl;

    // read-back from a selected cell, all zero when not selected
    typedef struct packed {
        logic              in_flag;
        logic              to_flag;
        logic [CH_W-1:0]   idx;
        logic [TIME_W-1:0] time_val;
        logic [MEM_W-1:0]  mem_val;
    } t_cell_rd;

    typedef struct packed {
        logic [MEM_W-1:0]  growth;
        logic [TIME_W-1:0] elapsed;
        logic [CH_W-1:0]   ch;
        logic [KIND_W-1:0] kind;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHK   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

endpackage

/* design/multi_channel_checkin_watchdog.sv */
// Multi-channel check-in watchdog: a row of channel cells with a scan token.
// Check in / check out: S_CHK forms the registered result word; no new command is taken
// until the state is back in S_IDLE. Tick: a token walks the cell row one cell per cycle
// while the output is not stalled; output stalls hold the token.
// Reset (i_rst_n low, synchronous) clears all flags, tick count and memory mark,
// and loads the timeout with 60. Depends on mcw_pkg and mcw_cell.
module multi_channel_checkin_watchdog #(
    parameter int CHANNELS = mcw_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mcw_pkg::TIME_W-1:0]  i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[1:0], channel[5:2], mem_sample_kb[45:6], zero fill
    input  logic [mcw_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // report_kind[2:0], report_channel[6:3], elapsed_ticks[38:7],
    // mem_growth_kb[78:39], zero fill
    output logic [mcw_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast
);
    import mcw_pkg::*;

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [TIME_W-1:0] r_tick, n_tick;
    logic [MEM_W-1:0]  r_hw, n_hw;
    logic [TIME_W-1:0] r_timeout;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pend_v, n_pend_v;
    t_result           r_pend, n_pend;
    logic              r_ov, n_ov;
    t_result           r_out, n_out;
    logic              r_olast, n_olast;

    t_cell_ctl         w_ctl;
    t_cell_rd          w_rd [CHANNELS];
    t_cell_rd          w_rd_or;
    logic [CHANNELS:0] w_tok;
    logic              w_acc;
    logic              w_start;
    logic              w_ofree;
    logic [TIME_W-1:0] w_el;
    logic [MEM_W-1:0]  w_gr;
    logic              w_hit;
    logic [CMD_W-1:0]  w_icmd;
    logic [CH_W-1:0]   w_ich;

    assign w_icmd  = s_axis_tdata[1:0];
    assign w_ich   = s_axis_tdata[5:2];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_start = w_acc && (w_icmd == CMD_TICK);
    assign w_ofree = !r_ov || m_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
            mcw_cell #(.IDX(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_tok   (w_tok[gi]),
                .o_tok   (w_tok[gi+1]),
                .o_rd    (w_rd[gi])
            );
        end
    endgenerate

    assign w_tok[0] = w_start;

    // at most one cell is selected, so an OR merges the read-back
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            w_rd_or = t_cell_rd'(w_rd_or | w_rd[i]);
        end
    end

    assign w_el  = r_tick - w_rd_or.time_val;
    assign w_gr  = r_hw - w_rd_or.mem_val;
    assign w_hit = (r_state == S_SCAN) && w_rd_or.in_flag && !w_rd_or.to_flag
                   && (w_el > r_timeout) && (r_cnt < CNT_W'(MAX_RESULTS));

    always_comb begin
        w_ctl        = '0;
        w_ctl.adv    = w_start || ((r_state == S_SCAN) && w_ofree);
        w_ctl.chk_rd = (r_state == S_CHK);
        w_ctl.ch     = r_ch;
        w_ctl.wr_in  = (r_state == S_CHK) && w_ofree && (r_cmd == CMD_CHECKIN)
                       && !w_rd_or.in_flag;
        w_ctl.clr_in = (r_state == S_CHK) && w_ofree && (r_cmd == CMD_CHECKOUT)
                       && w_rd_or.in_flag;
        w_ctl.mark   = w_hit && w_ofree;
        w_ctl.tick   = r_tick;
        w_ctl.mem    = r_hw;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_ch     = r_ch;
        n_tick   = r_tick;
        n_hw     = r_hw;
        n_cnt    = r_cnt;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_ov     = r_ov && !m_axis_tready;
        n_out    = r_out;
        n_olast  = r_olast;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_cmd = w_icmd;
                    n_ch  = w_ich;
                    if (w_icmd == CMD_TICK) begin
                        n_tick   = r_tick + 1'b1;
                        n_hw     = s_axis_tdata[45:6];
                        n_cnt    = '0;
                        n_pend_v = 1'b0;
                        n_state  = S_SCAN;
                    end else if ((w_icmd == CMD_CHECKIN || w_icmd == CMD_CHECKOUT)
                                 && (int'(w_ich) < CHANNELS)) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (w_ofree) begin
                    n_ov          = 1'b1;
                    n_olast       = 1'b1;
                    n_out         = '0;
                    n_out.ch      = r_ch;
                    if (r_cmd == CMD_CHECKIN) begin
                        n_out.kind = w_rd_or.in_flag ? RPT_DBL_CHECKIN : RPT_CHECKIN_OK;
                    end else if (!w_rd_or.in_flag) begin
                        n_out.kind = RPT_DBL_CHECKOUT;
                    end else if (w_rd_or.to_flag) begin
                        n_out.kind    = RPT_LATE_CHKOUT;
                        n_out.elapsed = w_el;
                        n_out.growth  = w_gr;
                    end else begin
                        n_out.kind = RPT_CHECKOUT_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_ofree) begin
                    // a hit holds back until the next one shows whether it is last
                    if (w_hit) begin
                        n_cnt          = r_cnt + 1'b1;
                        n_pend_v       = 1'b1;
                        n_pend.kind    = RPT_TIMEOUT;
                        n_pend.ch      = w_rd_or.idx;
                        n_pend.elapsed = w_el;
                        n_pend.growth  = w_gr;
                        if (r_pend_v) begin
                            n_ov    = 1'b1;
                            n_out   = r_pend;
                            n_olast = 1'b0;
                        end
                    end
                    if (w_tok[CHANNELS]) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_ofree) begin
                    n_ov     = 1'b1;
                    n_out    = r_pend;
                    n_olast  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_hw      <= '0;
            r_timeout <= TIMEOUT_RST;
            r_cnt     <= '0;
            r_pend_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_hw     <= n_hw;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ch    <= n_ch;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_out};
    assign m_axis_tlast  = r_olast;

endmodule

/* design/mcw_cell.sv */
// One watchdog channel cell: flags, check-in time and memory mark, scan token.
// Depends on mcw_pkg.
module mcw_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcw_pkg::t_cell_ctl i_ctl,
    input  logic              i_tok,
    output logic              o_tok,
    output mcw_pkg::t_cell_rd o_rd
);
    import mcw_pkg::*;

    localparam logic [CH_W-1:0] IDX_L = CH_W'(IDX);

    logic              r_in;
    logic              r_to;
    logic              r_tok;
    logic [TIME_W-1:0] r_time;
    logic [MEM_W-1:0]  r_mem;
    logic              w_sel;

    // channels past the 4-bit index range are never addressed
    assign w_sel = i_ctl.chk_rd && (IDX < (1 << CH_W)) && (i_ctl.ch == IDX_L);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in  <= 1'b0;
            r_to  <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            if (i_ctl.adv) begin
                r_tok <= i_tok;
            end
            if (w_sel && i_ctl.wr_in) begin
                r_in <= 1'b1;
                r_to <= 1'b0;
            end else if (w_sel && i_ctl.clr_in) begin
                r_in <= 1'b0;
            end else if (r_tok && i_ctl.mark) begin
                r_to <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_ctl.wr_in) begin
            r_time <= i_ctl.tick;
            r_mem  <= i_ctl.mem;
        end
    end

    assign o_tok = r_tok;

    always_comb begin
        o_rd = '0;
        if (w_sel || r_tok) begin
            o_rd.in_flag  = r_in;
            o_rd.to_flag  = r_to;
            o_rd.idx      = IDX_L;
            o_rd.time_val = r_time;
            o_rd.mem_val  = r_mem;
        end
    end

endmodule
